// File: hdl/quadratic_root_solver_assert.svh
// Assertion macros used by the quadratic root solver top level
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH

// Check a consequence in the same cycle; expects clk and rst in scope.
`define QRS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after the antecedent; expects clk and rst in scope.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/qrs_pkg.sv
// Types, widths, result codes and saturation helper for the quadratic root solver
package qrs_pkg;

  localparam int DATA_W  = 32;
  localparam int COEF_W  = DATA_W + 1;          // difference of two coefficients
  localparam int PROD_W  = 2 * COEF_W;          // product of two magnitudes
  localparam int RAD_W   = PROD_W + 2;          // discriminant magnitude, even width
  localparam int ROOT_W  = RAD_W / 2;
  localparam int NVAL_W  = ROOT_W + 2;          // signed numerator before scaling
  localparam int NUM_W   = 51;                  // scaled numerator magnitude
  localparam int DISC_W  = 2 * DATA_W;
  localparam int DSUM_W  = RAD_W + 1;           // signed b*b - 4ac

  localparam logic [2:0] KIND_TWO_REAL  = 3'd0;
  localparam logic [2:0] KIND_DOUBLE    = 3'd1;
  localparam logic [2:0] KIND_COMPLEX   = 3'd2;
  localparam logic [2:0] KIND_LINEAR    = 3'd3;
  localparam logic [2:0] KIND_NONE      = 3'd4;
  localparam logic [2:0] KIND_ALL_REALS = 3'd5;

  typedef struct packed {
    logic signed [DATA_W-1:0] left_square;
    logic signed [DATA_W-1:0] left_linear;
    logic signed [DATA_W-1:0] left_constant;
    logic signed [DATA_W-1:0] right_square;
    logic signed [DATA_W-1:0] right_linear;
    logic signed [DATA_W-1:0] right_constant;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] root_one;
    logic signed [DATA_W-1:0] root_two;
    logic signed [DATA_W-1:0] imag_part;
    logic signed [DISC_W-1:0] discriminant;
    logic                     overflow;
  } out_item_t;

  // Saturate a sign and magnitude quotient to 32 bits; top bit flags saturation.
  function automatic logic [DATA_W:0] sat_q(input logic [NUM_W-1:0] mag, input logic neg);
    logic [NUM_W-1:0] pos_lim;
    logic [NUM_W-1:0] neg_lim;
    pos_lim = NUM_W'(32'h7FFF_FFFF);
    neg_lim = NUM_W'(33'h0_8000_0000);
    if (!neg) begin
      if (mag > pos_lim) sat_q = {1'b1, 32'h7FFF_FFFF};
      else sat_q = {1'b0, mag[DATA_W-1:0]};
    end else begin
      if (mag > neg_lim) sat_q = {1'b1, 32'h8000_0000};
      else sat_q = {1'b0, (~mag[DATA_W-1:0]) + 32'd1};
    end
  endfunction

endpackage

// File: hdl/qrs_mul.sv
// Bit-serial unsigned multiplier, one multiplier bit per cycle
module qrs_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [qrs_pkg::COEF_W-1:0]    x,
  input  logic [qrs_pkg::COEF_W-1:0]    y,
  output logic                          done,
  output logic [qrs_pkg::PROD_W-1:0]    p
);

  localparam int CNT_W = $clog2(qrs_pkg::COEF_W);

  logic [qrs_pkg::COEF_W-1:0] mcand;
  logic [qrs_pkg::COEF_W-1:0] hi;
  logic [qrs_pkg::COEF_W-1:0] lo;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [qrs_pkg::COEF_W:0]   sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign p   = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(qrs_pkg::COEF_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= x;
      hi    <= '0;
      lo    <= y;
    end else if (busy) begin
      hi <= sum[qrs_pkg::COEF_W:1];
      lo <= {sum[0], lo[qrs_pkg::COEF_W-1:1]};
    end
  end

endmodule

// File: hdl/qrs_sqrt.sv
// Digit-serial integer square root, one root bit per cycle
module qrs_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qrs_pkg::RAD_W-1:0]   radicand,
  output logic                        done,
  output logic [qrs_pkg::ROOT_W-1:0]  root
);

  localparam int CNT_W = $clog2(qrs_pkg::ROOT_W);
  localparam int REM_W = qrs_pkg::ROOT_W + 3;

  logic [qrs_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      ge;

  assign rem_sh = {rem[REM_W-3:0], rad[qrs_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(qrs_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[qrs_pkg::RAD_W-3:0], 2'b00};
      rem  <= ge ? rem_sh - trial : rem_sh;
      root <= {root[qrs_pkg::ROOT_W-2:0], ge};
    end
  end

endmodule

// File: hdl/qrs_div.sv
// Restoring unsigned divider, one quotient bit per cycle
module qrs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qrs_pkg::NUM_W-1:0]   num,
  input  logic [qrs_pkg::COEF_W-1:0]  den,
  output logic                        done,
  output logic [qrs_pkg::NUM_W-1:0]   quo
);

  localparam int CNT_W = $clog2(qrs_pkg::NUM_W);

  logic [qrs_pkg::COEF_W-1:0] dreg;
  logic [qrs_pkg::COEF_W-1:0] rem;
  logic [qrs_pkg::COEF_W:0]   rem_sh;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic                       ge;

  assign rem_sh = {rem, quo[qrs_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(qrs_pkg::NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= num;
      dreg <= den;
      rem  <= '0;
    end else if (busy) begin
      rem <= ge ? qrs_pkg::COEF_W'(rem_sh - {1'b0, dreg}) : rem_sh[qrs_pkg::COEF_W-1:0];
      quo <= {quo[qrs_pkg::NUM_W-2:0], ge};
    end
  end

endmodule

// File: hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: sequencer, serial multiplier, square root and shared divider, result register
//
//   channel  | valid     | stall     | payload
//   ---------+-----------+-----------+--------------------------------
//   input    | in_valid  | in_stall  | in_item  (six Q16.16 coefficients)
//   output   | out_valid | out_stall | out_item (kind, roots, disc, overflow)
//
// One equation at a time. A quadratic takes two products on the bit-serial
// multiplier, then the square root, then two quotients on the shared divider
// (one for a double root); a linear equation needs one quotient and a
// degenerate one none.
// Reset is synchronous and clears the sequencer and the output valid flag.
// A result held under out_stall does not block the next transaction from
// being taken; the sequencer waits at the end only if the result is still held.
`include "quadratic_root_solver_assert.svh"

module quadratic_root_solver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  qrs_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output qrs_pkg::out_item_t out_item
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CLASS = 8'b0000_0010,
    S_MBB   = 8'b0000_0100,
    S_MAC   = 8'b0000_1000,
    S_DISC  = 8'b0001_0000,
    S_SQRT  = 8'b0010_0000,
    S_DIV   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;

  // Coefficient differences, exact at 33 bits
  logic signed [qrs_pkg::COEF_W-1:0] a, b, c;
  logic [qrs_pkg::COEF_W-1:0]        ua, ub, uc;

  logic [qrs_pkg::PROD_W-1:0] bb, ac;
  logic [2:0]                 kind;
  logic signed [qrs_pkg::DATA_W-1:0] r1, r2, im;
  logic [qrs_pkg::DISC_W-1:0] disc;
  logic                       ovf;
  logic                       job;
  logic                       last_job;
  logic                       div_neg;

  // Serial unit hookup
  logic                        mul_start, mul_done;
  logic [qrs_pkg::COEF_W-1:0]  mul_x, mul_y;
  logic [qrs_pkg::PROD_W-1:0]  mul_p;
  logic                        sqrt_start, sqrt_done;
  logic [qrs_pkg::ROOT_W-1:0]  s;
  logic                        div_start, div_done;
  logic [qrs_pkg::NUM_W-1:0]   div_num, div_q;
  logic [qrs_pkg::COEF_W-1:0]  div_den;

  // Discriminant path
  logic [qrs_pkg::DSUM_W-1:0]  bb_x, p4_x, dsum, dsum_n;
  logic                        d_neg;
  logic [qrs_pkg::RAD_W-2:0]   m;
  logic [qrs_pkg::DISC_W-1:0]  disc_c;
  logic                        disc_ovf;

  // Division operand selection
  logic signed [qrs_pkg::NVAL_W-1:0] nval, s_x, b_x, c_x;
  logic [qrs_pkg::NVAL_W-1:0]        nmag;
  logic signed [qrs_pkg::COEF_W-1:0] dval;
  logic                              sh16;
  logic                              dj;
  logic [qrs_pkg::DATA_W:0]          sat;

  assign in_stall = (state != S_IDLE);

  assign ua = a[qrs_pkg::COEF_W-1] ? -a : a;
  assign ub = b[qrs_pkg::COEF_W-1] ? -b : b;
  assign uc = c[qrs_pkg::COEF_W-1] ? -c : c;

  // b*b first, then |a|*|c| started as the first product lands
  assign mul_start = (state == S_CLASS && a != '0) || (state == S_MBB && mul_done);
  assign mul_x     = (state == S_CLASS) ? ub : ua;
  assign mul_y     = (state == S_CLASS) ? ub : uc;

  // Signed b*b - 4ac, then its magnitude for the square root
  assign bb_x   = qrs_pkg::DSUM_W'(bb);
  assign p4_x   = qrs_pkg::DSUM_W'({ac, 2'b00});
  assign dsum   = (a[qrs_pkg::COEF_W-1] ^ c[qrs_pkg::COEF_W-1]) ? bb_x + p4_x : bb_x - p4_x;
  assign dsum_n = -dsum;
  assign d_neg  = dsum[qrs_pkg::DSUM_W-1];
  assign m      = d_neg ? dsum_n[qrs_pkg::RAD_W-2:0] : dsum[qrs_pkg::RAD_W-2:0];

  always_comb begin
    disc_ovf = 1'b0;
    if (!d_neg) begin
      if (m > (qrs_pkg::RAD_W-1)'(64'h7FFF_FFFF_FFFF_FFFF)) begin
        disc_c   = 64'h7FFF_FFFF_FFFF_FFFF;
        disc_ovf = 1'b1;
      end else begin
        disc_c = m[qrs_pkg::DISC_W-1:0];
      end
    end else begin
      if (m > (qrs_pkg::RAD_W-1)'(65'h0_8000_0000_0000_0000)) begin
        disc_c   = 64'h8000_0000_0000_0000;
        disc_ovf = 1'b1;
      end else begin
        disc_c = -m[qrs_pkg::DISC_W-1:0];
      end
    end
  end

  assign sqrt_start = (state == S_DISC);

  // Pick numerator and divisor for the next quotient
  assign dj  = (state == S_DIV);
  assign s_x = qrs_pkg::NVAL_W'({1'b0, s});
  assign b_x = qrs_pkg::NVAL_W'(b);
  assign c_x = qrs_pkg::NVAL_W'(c);

  always_comb begin
    sh16 = 1'b0;
    dval = a;
    if (state == S_CLASS) begin
      nval = -c_x;
      dval = b;
      sh16 = 1'b1;
    end else if (dj) begin
      nval = (kind == qrs_pkg::KIND_TWO_REAL) ? -b_x - s_x : s_x;
    end else begin
      nval = (kind == qrs_pkg::KIND_TWO_REAL) ? s_x - b_x : -b_x;
    end
  end

  assign nmag    = nval[qrs_pkg::NVAL_W-1] ? -nval : nval;
  assign div_num = sh16 ? qrs_pkg::NUM_W'(nmag) << 16 : qrs_pkg::NUM_W'(nmag) << 15;
  assign div_den = dval[qrs_pkg::COEF_W-1] ? -dval : dval;
  assign div_start = (state == S_CLASS && a == '0 && b != '0) ||
                     (state == S_SQRT && sqrt_done) ||
                     (state == S_DIV && div_done && job != last_job);
  assign sat = qrs_pkg::sat_q(div_q, div_neg);

  qrs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .p     (mul_p)
  );

  qrs_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({1'b0, m}),
    .done     (sqrt_done),
    .root     (s)
  );

  qrs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  // Sequencer and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      job       <= 1'b0;
    end else begin
      // Load a fresh result when the register is free, drop a taken one
      if (state == S_FIN && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_CLASS;
        end
        S_CLASS: begin
          job <= 1'b0;
          if (a != '0) state <= S_MBB;
          else if (b != '0) state <= S_DIV;
          else state <= S_FIN;
        end
        S_MBB: begin
          if (mul_done) state <= S_MAC;
        end
        S_MAC: begin
          if (mul_done) state <= S_DISC;
        end
        S_DISC: begin
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (job == last_job) state <= S_FIN;
            else job <= 1'b1;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (div_start) div_neg <= nval[qrs_pkg::NVAL_W-1] ^ dval[qrs_pkg::COEF_W-1];
    case (state)
      S_IDLE: begin
        a <= qrs_pkg::COEF_W'(in_item.left_square) - qrs_pkg::COEF_W'(in_item.right_square);
        b <= qrs_pkg::COEF_W'(in_item.left_linear) - qrs_pkg::COEF_W'(in_item.right_linear);
        c <= qrs_pkg::COEF_W'(in_item.left_constant)
             - qrs_pkg::COEF_W'(in_item.right_constant);
      end
      S_CLASS: begin
        r1       <= '0;
        r2       <= '0;
        im       <= '0;
        disc     <= '0;
        ovf      <= 1'b0;
        last_job <= 1'b0;
        if (a == '0) begin
          if (b != '0) kind <= qrs_pkg::KIND_LINEAR;
          else if (c != '0) kind <= qrs_pkg::KIND_NONE;
          else kind <= qrs_pkg::KIND_ALL_REALS;
        end
      end
      S_MBB: begin
        if (mul_done) bb <= mul_p;
      end
      S_MAC: begin
        if (mul_done) ac <= mul_p;
      end
      S_DISC: begin
        disc <= disc_c;
        ovf  <= disc_ovf;
        if (m == '0) begin
          kind     <= qrs_pkg::KIND_DOUBLE;
          last_job <= 1'b0;
        end else if (!d_neg) begin
          kind     <= qrs_pkg::KIND_TWO_REAL;
          last_job <= 1'b1;
        end else begin
          kind     <= qrs_pkg::KIND_COMPLEX;
          last_job <= 1'b1;
        end
      end
      S_DIV: begin
        if (div_done) begin
          ovf <= ovf | sat[qrs_pkg::DATA_W];
          if (!job) begin
            r1 <= sat[qrs_pkg::DATA_W-1:0];
            if (kind == qrs_pkg::KIND_DOUBLE || kind == qrs_pkg::KIND_COMPLEX)
              r2 <= sat[qrs_pkg::DATA_W-1:0];
          end else if (kind == qrs_pkg::KIND_TWO_REAL) begin
            r2 <= sat[qrs_pkg::DATA_W-1:0];
          end else begin
            im <= sat[qrs_pkg::DATA_W-1:0];
          end
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          out_item.kind         <= kind;
          out_item.root_one     <= r1;
          out_item.root_two     <= r2;
          out_item.imag_part    <= im;
          out_item.discriminant <= disc;
          out_item.overflow     <= ovf;
        end
      end
      default: ;
    endcase
  end

  `QRS_ASSERT_NEXT(a_accept_class, in_valid && !in_stall, state == S_CLASS, "accept did not start work")
  `QRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "held result dropped")
  `QRS_ASSERT_NOW(a_kind_range, out_valid, out_item.kind <= qrs_pkg::KIND_ALL_REALS, "bad kind")
  `QRS_ASSERT_NOW(a_disc_zero, out_valid && out_item.kind >= qrs_pkg::KIND_LINEAR, out_item.discriminant == '0, "discriminant set for non-quadratic")

endmodule

// File: tb/sv/tb_quadratic_root_solver.sv
// Self-checking testbench for the quadratic root solver: directed table plus random equations
`timescale 1ns / 100ps

module tb_quadratic_root_solver;

  localparam int N_RANDOM = 700;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  qrs_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  qrs_pkg::out_item_t out_item;

  quadratic_root_solver DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Directed row: coefficients, and optionally a result typed in by hand.
  typedef struct {
    qrs_pkg::in_item_t  coef;
    bit                 typed;
    qrs_pkg::out_item_t answer;
  } row_t;

  qrs_pkg::out_item_t pending_roots[$];
  int                 mismatches;
  int                 results_seen;
  int                 kind_hits[6];
  bit                 done_driving;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Generous ceiling: every equation at its slowest, with long gaps and stalls.
  initial begin
    #(64'd8 * 64'd4_000_000);
    $display("tb_quadratic_root_solver NOT OK");
    $finish;
  end

  // Integer square root, rounded down, of a 68-bit magnitude.
  function automatic logic [35:0] isqrt_down(input logic [67:0] m);
    logic [35:0]  r;
    logic [35:0]  cand;
    logic [71:0]  sq;
    r = '0;
    for (int i = 35; i >= 0; i--) begin
      cand = r | (36'd1 << i);
      sq   = cand * cand;
      if (sq <= {4'd0, m}) r = cand;
    end
    return r;
  endfunction

  // Clamp to 32 bits signed, raising the overflow flag when clamped.
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v,
                                                 inout logic ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Work out the solution the block should report for one equation.
  function automatic qrs_pkg::out_item_t solve_equation(input qrs_pkg::in_item_t e);
    qrs_pkg::out_item_t    r;
    logic signed [63:0]    qa, qb, qc, s;
    logic signed [69:0]    dsum;
    logic [67:0]           mag;
    logic                  ovf;
    qa  = 64'(e.left_square)   - 64'(e.right_square);
    qb  = 64'(e.left_linear)   - 64'(e.right_linear);
    qc  = 64'(e.left_constant) - 64'(e.right_constant);
    ovf = 1'b0;
    r   = '0;
    if (qa != 0) begin
      dsum = 70'(qb) * 70'(qb) - 70'sd4 * 70'(qa) * 70'(qc);
      mag  = dsum < 0 ? 68'(-dsum) : 68'(dsum);
      if (dsum > 70'sh7FFF_FFFF_FFFF_FFFF) begin
        r.discriminant = 64'h7FFF_FFFF_FFFF_FFFF;
        ovf = 1'b1;
      end else if (dsum < -70'sh8000_0000_0000_0000) begin
        r.discriminant = 64'h8000_0000_0000_0000;
        ovf = 1'b1;
      end else begin
        r.discriminant = dsum[63:0];
      end
      s = 64'(isqrt_down(mag));
      // SV division truncates toward zero, as the fixed-point divider does.
      if (dsum == 0) begin
        r.kind     = qrs_pkg::KIND_DOUBLE;
        r.root_one = clamp32((-qb) * 32768 / qa, ovf);
        r.root_two = r.root_one;
      end else if (dsum > 0) begin
        r.kind     = qrs_pkg::KIND_TWO_REAL;
        r.root_one = clamp32((s - qb) * 32768 / qa, ovf);
        r.root_two = clamp32((-qb - s) * 32768 / qa, ovf);
      end else begin
        r.kind      = qrs_pkg::KIND_COMPLEX;
        r.root_one  = clamp32((-qb) * 32768 / qa, ovf);
        r.root_two  = r.root_one;
        r.imag_part = clamp32(s * 32768 / qa, ovf);
      end
    end else if (qb != 0) begin
      r.kind     = qrs_pkg::KIND_LINEAR;
      r.root_one = clamp32((-qc) * 65536 / qb, ovf);
    end else if (qc != 0) begin
      r.kind = qrs_pkg::KIND_NONE;
    end else begin
      r.kind = qrs_pkg::KIND_ALL_REALS;
    end
    r.overflow = ovf;
    return r;
  endfunction

  function automatic qrs_pkg::in_item_t coefs(input logic [31:0] ls, lb, lc, rs, rb, rc);
    qrs_pkg::in_item_t e;
    e.left_square    = ls;
    e.left_linear    = lb;
    e.left_constant  = lc;
    e.right_square   = rs;
    e.right_linear   = rb;
    e.right_constant = rc;
    return e;
  endfunction

  // Mostly short gaps, occasionally a long one, sometimes none at all.
  function automatic int gap_length();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  function automatic logic [31:0] random_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return {$urandom_range(0, 3) == 0 ? 16'hFFFF : 16'h0000,
                 16'($urandom)};
      3: return 32'($urandom_range(0, 6)) << 16;
      4: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 64)) - 32) << 16;
    endcase
  endfunction

  // Build one random equation; steer it towards the rarer outcomes at times.
  function automatic qrs_pkg::in_item_t random_equation();
    qrs_pkg::in_item_t e;
    logic [31:0] k;
    e = coefs(random_coef(), random_coef(), random_coef(),
              random_coef(), random_coef(), random_coef());
    case ($urandom_range(0, 9))
      0: e.right_square = e.left_square;                     // linear
      1: begin                                               // degenerate
        e.right_square = e.left_square;
        e.right_linear = e.left_linear;
        if ($urandom_range(0, 1)) e.right_constant = e.left_constant;
      end
      2: begin                                               // double root
        // (x - k)^2 in whole units: a = 1, b = -2k, c = k*k
        k = 32'($signed($urandom_range(0, 200)) - 100);
        e = coefs(32'h0001_0000, 32'(-2 * $signed(k)) << 16,
                  32'($signed(k) * $signed(k)) << 16, 0, 0, 0);
      end
      default: ;
    endcase
    return e;
  endfunction

  // Drop valid only for a real gap, so back-to-back items keep it high.
  task automatic send_equation(input qrs_pkg::in_item_t e);
    int g;
    g = gap_length();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: record what it should produce
    pending_roots.push_back(solve_equation(e));
  endtask

  // Directed table and random phase.
  initial begin
    row_t rows[$];
    row_t rw;
    qrs_pkg::out_item_t z;

    in_valid     = 1'b0;
    in_item      = '0;
    rst          = 1'b1;
    done_driving = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    z = '0;
    // all coefficients zero: every x solves it
    rw.coef = coefs(0, 0, 0, 0, 0, 0); rw.typed = 1;
    rw.answer = z; rw.answer.kind = qrs_pkg::KIND_ALL_REALS; rows.push_back(rw);
    // only a constant: no solution
    rw.coef = coefs(0, 0, 32'h0001_0000, 0, 0, 0); rw.typed = 1;
    rw.answer = z; rw.answer.kind = qrs_pkg::KIND_NONE; rows.push_back(rw);
    // equal sides with extreme values: all reals
    rw.coef = coefs(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    rw.answer = z; rw.answer.kind = qrs_pkg::KIND_ALL_REALS; rows.push_back(rw);
    // x - 2 = 0: linear root 2
    rw.coef = coefs(0, 32'h0001_0000, 32'hFFFE_0000, 0, 0, 0);
    rw.answer = z; rw.answer.kind = qrs_pkg::KIND_LINEAR;
    rw.answer.root_one = 32'h0002_0000; rows.push_back(rw);
    // linear root too large: saturates
    rw.coef = coefs(0, 32'h0000_0001, 32'h7FFF_FFFF, 0, 0, 0);
    rw.answer = z; rw.answer.kind = qrs_pkg::KIND_LINEAR;
    rw.answer.root_one = 32'h8000_0000; rw.answer.overflow = 1; rows.push_back(rw);
    rw.typed = 0;
    // x^2 - 1: two real roots; x^2 - 2x + 1: double; x^2 + 1: complex
    rw.coef = coefs(32'h0001_0000, 0, 32'hFFFF_0000, 0, 0, 0); rows.push_back(rw);
    rw.coef = coefs(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000, 0, 0, 0);
    rows.push_back(rw);
    rw.coef = coefs(32'h0001_0000, 0, 32'h0001_0000, 0, 0, 0); rows.push_back(rw);
    // negative a complex pair, so the imaginary part is negative
    rw.coef = coefs(32'hFFFF_0000, 32'h0002_0000, 32'hFFFB_0000, 0, 0, 0);
    rows.push_back(rw);
    // extremes: 33-bit differences, discriminant past 64 bits both ways
    rw.coef = coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    rows.push_back(rw);
    rw.coef = coefs(32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                    32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    rows.push_back(rw);
    rw.coef = coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0);
    rows.push_back(rw);
    rw.coef = coefs(32'h0000_0001, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0);
    rows.push_back(rw);
    rw.coef = coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    rows.push_back(rw);
    rw.coef = coefs(32'h0000_0001, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
    rows.push_back(rw);
    rw.coef = coefs(32'hFFFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555,
                    32'h0000_0001, 32'hAAAA_5555, 32'h5555_AAAA);
    rows.push_back(rw);

    foreach (rows[i]) begin
      send_equation(rows[i].coef);
      if (rows[i].typed) begin
        // the hand-worked answer must agree with the predictor as well
        if (pending_roots[$] !== rows[i].answer) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: typed answer %p, predicted %p",
                     i, rows[i].answer, pending_roots[$]);
        end
        pending_roots[$] = rows[i].answer;
      end
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) begin
        // drain fully once before carrying on
        in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge clk);
      end
      send_equation(random_equation());
    end

    in_valid <= 1'b0;
    while (pending_roots.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    done_driving = 1'b1;
  end

  // Receiver: random stalls, compare each transaction against the oldest expectation.
  initial begin
    qrs_pkg::out_item_t want;
    int hold;
    out_stall    = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    hold         = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        results_seen++;
        if (pending_roots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_item);
        end else begin
          want = pending_roots.pop_front();
          if (want.kind < 6) kind_hits[want.kind]++;
          if (out_item !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch %0d: want kind %0d r1 %h r2 %h im %h d %h o %b | got kind %0d r1 %h r2 %h im %h d %h o %b",
                       results_seen, want.kind, want.root_one, want.root_two,
                       want.imag_part, want.discriminant, want.overflow,
                       out_item.kind, out_item.root_one, out_item.root_two,
                       out_item.imag_part, out_item.discriminant, out_item.overflow);
          end
        end
      end
      if (hold > 0) begin
        hold--;
      end else begin
        hold = gap_length();
      end
      out_stall <= (hold > 0);
    end
  end

  // Final verdict.
  initial begin
    wait (done_driving);
    if (pending_roots.size() != 0) mismatches++;
    $display("Checked %0d results: two real %0d, double %0d, complex %0d,", results_seen,
             kind_hits[0], kind_hits[1], kind_hits[2]);
    $display("  linear %0d, no solution %0d, all reals %0d; %0d mismatches",
             kind_hits[3], kind_hits[4], kind_hits[5], mismatches);
    if (mismatches == 0) begin
      $display("tb_quadratic_root_solver OK");
    end else begin
      $display("tb_quadratic_root_solver NOT OK");
    end
    $finish;
  end

endmodule
